/* rtl/hssc_pkg.sv */
// Package for the half-step stepper controller: shared constants, codes,
// the command/status structs between controller and datapath, and pattern tables.
// No dependencies.
package hssc_pkg;

  // Sequence and duty scaling.
  localparam int SEQ_LENGTH = 8;
  localparam int IDX_W      = $clog2(SEQ_LENGTH);
  localparam int FULL_DUTY  = 1600;
  localparam int DUTY_W     = 11;
  localparam int POWER_W    = 10;
  localparam int PERMILLE   = 1000;

  // Power times FULL_DUTY, and the reciprocal used to divide it by 1000.
  localparam int SCALED_W   = POWER_W + DUTY_W;
  localparam int RECIP_SH   = 31;
  localparam int RECIP_W    = 22;
  localparam logic [RECIP_W-1:0] RECIP_1000 =
    RECIP_W'(((64'd1 << RECIP_SH) + 64'(PERMILLE) - 64'd1) / 64'(PERMILLE));
  localparam int PROD_W     = SCALED_W + RECIP_W;

  // Field widths.
  localparam int FREQ_W     = 20;
  localparam int STEPS_W    = 32;
  localparam int POS_W      = 32;
  localparam int DELAY_W    = 24;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  // Half-period divider: 500000 / |freq|.
  localparam int DIVIDEND   = 500000;
  localparam int QUO_W      = $clog2(DIVIDEND + 1);
  localparam int DIV_STEPS  = QUO_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  // Reset values of the configuration registers.
  localparam logic [POWER_W-1:0] RUN_POWER_RST    = POWER_W'(1000);
  localparam logic [POWER_W-1:0] REST_POWER_RST   = POWER_W'(300);
  localparam logic [DELAY_W-1:0] HOLD_DELAY_RST   = DELAY_W'(100000);
  localparam logic [SCALED_W-1:0] HOLD_SCALED_RST = SCALED_W'(300 * FULL_DUTY);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_RUN_POWER      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_REST_POWER     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_DELAY     = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_START_POSITION = CFG_IDX_W'(3);

  // Item modes.
  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_MOVE = 1'b1;

  typedef enum logic [1:0] {
    POL_OFF = 2'd0,
    POL_POS = 2'd1,
    POL_NEG = 2'd2
  } pol_t;

  typedef enum logic [1:0] {
    ST_HOLDING  = 2'd0,
    ST_ROTATING = 2'd1,
    ST_STOPPED  = 2'd2
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic run_tick;
    logic div_init;
    logic div_step;
    logic commit_move;
    logic load_out;
  } hssc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_move;
    logic freq_zero;
  } hssc_sts_t;

  // One result beat.
  typedef struct packed {
    pol_t                coil_a_polarity;
    logic [DUTY_W-1:0]   coil_a_duty;
    pol_t                coil_b_polarity;
    logic [DUTY_W-1:0]   coil_b_duty;
    status_t             motor_status;
    logic [POS_W-1:0]    position;
    logic [STEPS_W-1:0]  steps_remaining;
  } hssc_res_t;

  // Reduce a sequence index to its place in the eight-entry pattern.
  function automatic logic [2:0] pat_sel(input logic [IDX_W-1:0] idx);
    logic [IDX_W+2:0] wide;
    wide = {3'b000, idx};
    return wide[2:0];
  endfunction

  // Half-step pattern, phase A.
  function automatic pol_t pat_a(input logic [2:0] sel);
    pol_t p;
    case (sel)
      3'd0:    p = POL_POS;
      3'd1:    p = POL_OFF;
      3'd2:    p = POL_NEG;
      3'd3:    p = POL_NEG;
      3'd4:    p = POL_NEG;
      3'd5:    p = POL_OFF;
      3'd6:    p = POL_POS;
      default: p = POL_POS;
    endcase
    return p;
  endfunction

  // Half-step pattern, phase B.
  function automatic pol_t pat_b(input logic [2:0] sel);
    pol_t p;
    case (sel)
      3'd0:    p = POL_POS;
      3'd1:    p = POL_POS;
      3'd2:    p = POL_POS;
      3'd3:    p = POL_OFF;
      3'd4:    p = POL_NEG;
      3'd5:    p = POL_NEG;
      3'd6:    p = POL_NEG;
      default: p = POL_OFF;
    endcase
    return p;
  endfunction

endpackage

/* rtl/hssc_if.sv */
// Channel interfaces of the half-step stepper controller: item input,
// result output and configuration write. Depends on hssc_pkg.

interface hssc_cmd_if import hssc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                mode;
  logic [FREQ_W-1:0]   move_frequency;
  logic [STEPS_W-1:0]  move_steps;

  modport source (output valid, mode, move_frequency, move_steps, input ready);
  modport sink   (input valid, mode, move_frequency, move_steps, output ready);
endinterface

interface hssc_res_if import hssc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [1:0]          coil_a_polarity;
  logic [DUTY_W-1:0]   coil_a_duty;
  logic [1:0]          coil_b_polarity;
  logic [DUTY_W-1:0]   coil_b_duty;
  logic [1:0]          motor_status;
  logic [POS_W-1:0]    position;
  logic [STEPS_W-1:0]  steps_remaining;

  modport source (output valid, coil_a_polarity, coil_a_duty, coil_b_polarity, coil_b_duty,
                  motor_status, position, steps_remaining, input ready);
  modport sink   (input valid, coil_a_polarity, coil_a_duty, coil_b_polarity, coil_b_duty,
                  motor_status, position, steps_remaining, output ready);
endinterface

interface hssc_cfg_if import hssc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_IDX_W-1:0]   index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/hssc_datapath.sv */
// Datapath of the half-step stepper controller: configuration registers,
// motor state, serial half-period divider, coil duty scaling and result register.
// Depends on hssc_pkg.
module hssc_datapath import hssc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  hssc_cmd_t              cmd,
  output hssc_sts_t              sts,
  input  logic                   in_mode,
  input  logic [FREQ_W-1:0]      in_frequency,
  input  logic [STEPS_W-1:0]     in_steps,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output hssc_res_t              res_data
);

  typedef enum logic [1:0] {
    PH_HOLD  = 2'd0,
    PH_START = 2'd1,
    PH_END   = 2'd2,
    PH_WAIT  = 2'd3
  } phase_t;

  localparam logic [IDX_W-1:0]   IDX_LAST = IDX_W'(SEQ_LENGTH - 1);
  localparam logic [DELAY_W-1:0] IDLE_MAX = {DELAY_W{1'b1}};

  // Configuration registers; a start position write goes straight to the counter.
  logic [POWER_W-1:0]  run_power;
  logic [POWER_W-1:0]  rest_power;
  logic [DELAY_W-1:0]  hold_delay;

  // Motor state.
  logic [IDX_W-1:0]    table_index;
  phase_t              fsm_phase;
  logic [QUO_W-1:0]    wait_left;
  logic                reverse;
  logic [QUO_W-1:0]    half_period;
  logic [STEPS_W-1:0]  steps_left;
  logic [POS_W-1:0]    step_position;
  logic [DELAY_W-1:0]  idle_ticks;
  status_t             status_reg;
  logic [2:0]          drv_sel;
  logic [SCALED_W-1:0] drv_scaled;

  // Latched item.
  logic                item_mode;
  logic [FREQ_W-1:0]   item_freq;
  logic [STEPS_W-1:0]  item_steps;

  // Divider registers.
  logic [FREQ_W-1:0]   div_mag;
  logic [FREQ_W-1:0]   div_rem;
  logic [QUO_W-1:0]    div_num;
  logic [QUO_W-1:0]    div_quo;

  // Result register.
  hssc_res_t           res_reg;

  logic [IDX_W-1:0]    idx_next;
  logic [STEPS_W-1:0]  steps_dec;
  logic [FREQ_W:0]     div_trial;
  logic [FREQ_W-1:0]   freq_mag;
  logic [PROD_W-1:0]   duty_prod;
  logic [DUTY_W-1:0]   duty_quot;
  logic [DUTY_W-1:0]   duty_mag;

  assign sts.is_move   = (item_mode == MODE_MOVE);
  assign sts.freq_zero = (item_freq == '0);
  assign res_data      = res_reg;

  // Next sequence index in the direction of travel.
  always_comb begin
    if (reverse) begin
      idx_next = (table_index == '0) ? IDX_LAST : table_index - IDX_W'(1);
    end else begin
      idx_next = (table_index == IDX_LAST) ? '0 : table_index + IDX_W'(1);
    end
  end

  assign steps_dec = (steps_left != '0) ? steps_left - STEPS_W'(1) : '0;

  // Two's complement magnitude of the move frequency.
  assign freq_mag  = item_freq[FREQ_W-1] ? (~item_freq + FREQ_W'(1)) : item_freq;
  assign div_trial = {div_rem, div_num[QUO_W-1]};

  // Duty = drive power * FULL_DUTY / 1000, saturated.
  assign duty_prod = PROD_W'(drv_scaled) * PROD_W'(RECIP_1000);
  assign duty_quot = duty_prod[RECIP_SH +: DUTY_W];
  assign duty_mag  = (duty_quot > DUTY_W'(FULL_DUTY)) ? DUTY_W'(FULL_DUTY) : duty_quot;

  // Configuration registers and motor state.
  always_ff @(posedge clk) begin
    if (rst) begin
      run_power      <= RUN_POWER_RST;
      rest_power     <= REST_POWER_RST;
      hold_delay     <= HOLD_DELAY_RST;
      table_index    <= '0;
      fsm_phase      <= PH_HOLD;
      wait_left      <= '0;
      reverse        <= 1'b0;
      half_period    <= '0;
      steps_left     <= '0;
      step_position  <= '0;
      idle_ticks     <= '0;
      status_reg     <= ST_HOLDING;
      drv_sel        <= '0;
      drv_scaled     <= HOLD_SCALED_RST;
    end else begin
      // Move command: direction, half-period and step count.
      if (cmd.commit_move) begin
        reverse     <= item_freq[FREQ_W-1];
        half_period <= div_quo;
        steps_left  <= item_steps;
      end

      // One microsecond tick.
      if (cmd.run_tick) begin
        if (wait_left != '0) begin
          wait_left <= wait_left - QUO_W'(1);
        end else begin
          case (fsm_phase)
            PH_HOLD: begin
              if (steps_left != '0) begin
                drv_sel    <= pat_sel(table_index);
                drv_scaled <= SCALED_W'(run_power) * SCALED_W'(FULL_DUTY);
                fsm_phase  <= PH_START;
                wait_left  <= half_period;
              end
            end
            PH_START: begin
              status_reg  <= ST_ROTATING;
              table_index <= idx_next;
              drv_sel     <= pat_sel(idx_next);
              drv_scaled  <= SCALED_W'(run_power) * SCALED_W'(FULL_DUTY);
              fsm_phase   <= PH_END;
              wait_left   <= half_period;
            end
            PH_END: begin
              if (!table_index[0]) begin
                step_position <= reverse ? step_position - POS_W'(1)
                                         : step_position + POS_W'(1);
                steps_left    <= steps_dec;
                if (steps_dec == '0) begin
                  idle_ticks <= '0;
                  fsm_phase  <= PH_WAIT;
                  status_reg <= ST_STOPPED;
                end else begin
                  fsm_phase  <= PH_START;
                end
              end else begin
                fsm_phase <= PH_START;
              end
              wait_left <= '0;
            end
            default: begin
              if (idle_ticks >= hold_delay) begin
                drv_sel    <= pat_sel(table_index);
                drv_scaled <= SCALED_W'(rest_power) * SCALED_W'(FULL_DUTY);
                fsm_phase  <= PH_HOLD;
                status_reg <= ST_HOLDING;
              end else if (steps_left != '0) begin
                fsm_phase  <= PH_START;
              end else if (idle_ticks != IDLE_MAX) begin
                idle_ticks <= idle_ticks + DELAY_W'(1);
              end
              wait_left <= '0;
            end
          endcase
        end
      end

      // Configuration writes; the start position loads the counter.
      if (cfg_we) begin
        case (cfg_index)
          CFG_RUN_POWER:      run_power     <= cfg_data[POWER_W-1:0];
          CFG_REST_POWER:     rest_power    <= cfg_data[POWER_W-1:0];
          CFG_HOLD_DELAY:     hold_delay    <= cfg_data[DELAY_W-1:0];
          CFG_START_POSITION: step_position <= cfg_data[POS_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Item latch and restoring divider, one quotient bit per step.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_mode  <= in_mode;
      item_freq  <= in_frequency;
      item_steps <= in_steps;
    end
    if (cmd.div_init) begin
      div_mag <= freq_mag;
      div_rem <= '0;
      div_num <= QUO_W'(DIVIDEND);
      div_quo <= '0;
    end else if (cmd.div_step) begin
      if (div_trial >= {1'b0, div_mag}) begin
        div_rem <= FREQ_W'(div_trial - {1'b0, div_mag});
        div_quo <= {div_quo[QUO_W-2:0], 1'b1};
      end else begin
        div_rem <= div_trial[FREQ_W-1:0];
        div_quo <= {div_quo[QUO_W-2:0], 1'b0};
      end
      div_num <= {div_num[QUO_W-2:0], 1'b0};
    end
  end

  // Result register, loaded when the controller publishes a beat.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (pat_a(drv_sel) == POL_OFF || duty_mag == '0) begin
        res_reg.coil_a_polarity <= POL_OFF;
        res_reg.coil_a_duty     <= '0;
      end else begin
        res_reg.coil_a_polarity <= pat_a(drv_sel);
        res_reg.coil_a_duty     <= duty_mag;
      end
      if (pat_b(drv_sel) == POL_OFF || duty_mag == '0) begin
        res_reg.coil_b_polarity <= POL_OFF;
        res_reg.coil_b_duty     <= '0;
      end else begin
        res_reg.coil_b_polarity <= pat_b(drv_sel);
        res_reg.coil_b_duty     <= duty_mag;
      end
      res_reg.motor_status    <= status_reg;
      res_reg.position        <= step_position;
      res_reg.steps_remaining <= steps_left;
    end
  end

  // The sequence index never leaves the sequence.
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    table_index <= IDX_LAST)
    else $error("table index beyond sequence length");

  // Waiting for the hold timeout is only ever reported as stopped.
  a_wait_stopped: assert property (@(posedge clk) disable iff (rst)
    fsm_phase == PH_WAIT |-> status_reg == ST_STOPPED)
    else $error("hold wait phase without stopped status");

  // The hold phase is entered only with the holding status.
  a_hold_holding: assert property (@(posedge clk) disable iff (rst)
    fsm_phase == PH_HOLD |-> status_reg == ST_HOLDING)
    else $error("hold phase without holding status");

endmodule

/* rtl/hssc_ctrl.sv */
// Controller of the half-step stepper controller: sequences accept, divide,
// tick update and result publish through commands to the datapath.
// Depends on hssc_pkg.
module hssc_ctrl import hssc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_ready,
  output logic       res_valid,
  input  logic       res_ready,
  input  hssc_sts_t  sts,
  output hssc_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_DIV,
    S_COMMIT,
    S_PUB
  } state_t;

  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  state_t               state;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic                 accept;
  logic                 out_free;

  assign cmd_ready = (state == S_IDLE);
  assign accept    = cmd_valid && cmd_ready;
  assign out_free  = !res_valid || res_ready;

  // Commands decoded from the current state.
  always_comb begin
    cmd             = '0;
    cmd.load_item   = accept;
    cmd.run_tick    = (state == S_DISPATCH) && !sts.is_move;
    cmd.div_init    = (state == S_DISPATCH) && sts.is_move && !sts.freq_zero;
    cmd.div_step    = (state == S_DIV);
    cmd.commit_move = (state == S_COMMIT);
    cmd.load_out    = (state == S_PUB) && out_free;
  end

  // State, divide counter and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      div_cnt   <= '0;
      res_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          div_cnt <= '0;
          if (sts.is_move && !sts.freq_zero) begin
            state <= S_DIV;
          end else begin
            state <= S_PUB;
          end
        end
        S_DIV: begin
          div_cnt <= div_cnt + DIV_CNT_W'(1);
          if (div_cnt == DIV_LAST) begin
            state <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          state <= S_PUB;
        end
        S_PUB: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      // Result valid rises with a published beat and falls once it is taken.
      if (cmd.load_out) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // The divide counter stays within the quotient length.
  a_div_range: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> div_cnt <= DIV_LAST)
    else $error("divide counter overran");

  // A result is never loaded over one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!res_valid || res_ready))
    else $error("result register overwritten");

  // Every accepted item is dispatched in the next cycle.
  a_dispatch: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_DISPATCH)
    else $error("accepted item not dispatched");

endmodule

/* rtl/half_step_stepper_controller_top.sv */
// Top level of the half-step stepper controller: joins controller, datapath
// and the channel interfaces. Depends on hssc_pkg, hssc_if, hssc_ctrl, hssc_datapath.
//
//   Channel  Direction  Beat carries
//   cmd      in         mode, move_frequency, move_steps
//   res      out        coil A/B polarity and duty, motor_status, position, steps_remaining
//   cfg      in         register index and write data (always ready)
//
// A tick or an ignored move goes from accept through dispatch and publish back to idle.
// A move with a nonzero frequency adds the divide and commit steps: the serial divider
// produces one half-period bit per cycle.
// Reset is synchronous; divider, item and result registers are not reset, all others are.
// A stalled result holds in the output register; the next item is still accepted
// and waits in the publish step until that result is taken.
module half_step_stepper_controller_top import hssc_pkg::*; (
  input logic        clk,
  input logic        rst,
  hssc_cmd_if.sink   cmd,
  hssc_res_if.source res,
  hssc_cfg_if.sink   cfg
);

  hssc_cmd_t cmd_bus;
  hssc_sts_t sts_bus;
  hssc_res_t res_data;

  assign cfg.ready = 1'b1;

  hssc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .sts       (sts_bus),
    .cmd       (cmd_bus)
  );

  hssc_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd_bus),
    .sts          (sts_bus),
    .in_mode      (cmd.mode),
    .in_frequency (cmd.move_frequency),
    .in_steps     (cmd.move_steps),
    .cfg_we       (cfg.valid),
    .cfg_index    (cfg.index),
    .cfg_data     (cfg.data),
    .res_data     (res_data)
  );

  // Result payload onto the output channel.
  assign res.coil_a_polarity = res_data.coil_a_polarity;
  assign res.coil_a_duty     = res_data.coil_a_duty;
  assign res.coil_b_polarity = res_data.coil_b_polarity;
  assign res.coil_b_duty     = res_data.coil_b_duty;
  assign res.motor_status    = res_data.motor_status;
  assign res.position        = res_data.position;
  assign res.steps_remaining = res_data.steps_remaining;

endmodule
